>>> hw/rtl/alm_pkg.sv
package alm_pkg;

    localparam int unsigned CMD_W    = 2;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned FIELD_W  = 32;
    localparam int unsigned TOTAL_W  = 7;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_HIT       = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD1,
        S_ADD2,
        S_WALK,
        S_REM1,
        S_REM2,
        S_RESP
    } t_state;

endpackage

>>> hw/rtl/alm_ram.sv
module alm_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/alm_link_mem.sv
module alm_link_mem #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_clear,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [$clog2(DEPTH+1)-1:0] i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [$clog2(DEPTH+1)-1:0] o_rdata
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned LW = $clog2(DEPTH + 1);

    logic [DEPTH-1:0] r_vld;
    logic             r_rd_vld;
    logic [AW-1:0]    r_rd_addr;
    logic [LW-1:0]    ram_q;
    logic [AW:0]      rst_val;

    alm_ram #(
        .WIDTH (LW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_we),
        .i_waddr (i_waddr),
        .i_wdata (i_wdata),
        .i_raddr (i_raddr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_vld  <= r_vld[i_raddr];
        r_rd_addr <= i_raddr;
    end

    // untouched entries hold the free chain in index order
    assign rst_val = {1'b0, r_rd_addr} + {{AW{1'b0}}, 1'b1};
    assign o_rdata = r_rd_vld ? ram_q : LW'(rst_val);

endmodule

>>> hw/rtl/array_linked_list_multimap_core.sv
// Key/value multimap kept as a linked list in a pair memory and a next-link
// memory, with unused slots on a free chain. One command is worked at a time;
// i_valid/o_ready take the next item as soon as the previous command is
// finished, even while its last result still waits in the output register.
// Add steps through S_ADD1, S_ADD2 and S_RESP. Remove and search walk the
// list one entry at a time (up to CAPACITY entries), paced by the loop from
// the registered link read back to the next read address; search also
// stalls while a hit cannot be handed to the output register. Remove of a
// match that leaves pairs in the map adds the S_REM2 step.
// Link entries come out of reset as the index-order free chain through per
// entry valid flags, so no clearing pass follows reset; the pair store is
// read only at linked slots and is never cleared.
module array_linked_list_multimap_core import alm_pkg::*; #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [CMD_W-1:0]           i_command,
    input  logic signed [FIELD_W-1:0]  i_key,
    input  logic signed [FIELD_W-1:0]  i_value,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [STATUS_W-1:0]        o_status,
    output logic signed [FIELD_W-1:0]  o_found_value,
    output logic                       o_last,
    output logic [TOTAL_W-1:0]         o_pair_total
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned LW = $clog2(CAPACITY + 1);
    localparam logic [LW-1:0] NONE = LW'(CAPACITY);

    t_state r_state, n_state;

    logic [LW-1:0]       r_head, n_head;
    logic [LW-1:0]       r_tail, n_tail;
    logic [LW-1:0]       r_free, n_free;
    logic [LW-1:0]       r_count, n_count;
    logic                r_pend, n_pend;
    logic                r_ovalid, n_ovalid;

    logic [CMD_W-1:0]    r_cmd, n_cmd;
    logic [FIELD_W-1:0]  r_key, n_key;
    logic [FIELD_W-1:0]  r_value, n_value;
    logic [LW-1:0]       r_cur, n_cur;
    logic [LW-1:0]       r_prev, n_prev;
    logic [LW-1:0]       r_nxt, n_nxt;
    logic [LW-1:0]       r_slot, n_slot;
    logic [LW-1:0]       r_steps, n_steps;
    logic [FIELD_W-1:0]  r_pend_val, n_pend_val;
    logic [STATUS_W-1:0] r_rsp_status, n_rsp_status;
    logic [FIELD_W-1:0]  r_rsp_val, n_rsp_val;
    logic [STATUS_W-1:0] r_ostatus, n_ostatus;
    logic [FIELD_W-1:0]  r_oval, n_oval;
    logic                r_olast, n_olast;
    logic [LW-1:0]       r_ototal, n_ototal;

    logic                link_clear, link_we;
    logic [AW-1:0]       link_waddr, link_raddr;
    logic [LW-1:0]       link_wdata, link_q;
    logic                kv_we;
    logic [AW-1:0]       kv_waddr, kv_raddr;
    logic [2*FIELD_W-1:0] kv_wdata, kv_q;

    logic                cur_ok, key_hit, pair_hit, out_free, is_full, walk_adv;
    logic                is_remove;
    logic [LW-1:0]       cnt_dec;

    alm_link_mem #(
        .DEPTH (CAPACITY)
    ) u_link (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (link_clear),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (link_raddr),
        .o_rdata (link_q)
    );

    alm_ram #(
        .WIDTH (2 * FIELD_W),
        .DEPTH (CAPACITY)
    ) u_pairs (
        .i_clk   (i_clk),
        .i_we    (kv_we),
        .i_waddr (kv_waddr),
        .i_wdata (kv_wdata),
        .i_raddr (kv_raddr),
        .o_rdata (kv_q)
    );

    assign is_remove = (r_cmd == CMD_REMOVE);
    assign cur_ok    = (r_cur < NONE) && (r_steps < NONE);
    assign key_hit   = (kv_q[2*FIELD_W-1:FIELD_W] == r_key);
    assign pair_hit  = key_hit && (kv_q[FIELD_W-1:0] == r_value);
    assign out_free  = !r_ovalid || i_ready;
    assign is_full   = (r_free >= NONE) || (r_count >= NONE);
    assign walk_adv  = cur_ok && (is_remove ? !pair_hit : !(key_hit && r_pend && !out_free));
    assign cnt_dec   = r_count - LW'(1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_command)
                        CMD_ADD:    n_state = is_full ? S_RESP : S_ADD1;
                        CMD_REMOVE: n_state = S_WALK;
                        CMD_SEARCH: n_state = S_WALK;
                        default:    n_state = S_RESP;
                    endcase
                end
            end
            S_ADD1: n_state = S_ADD2;
            S_ADD2: n_state = S_RESP;
            S_WALK: begin
                if (!cur_ok) begin
                    n_state = S_RESP;
                end else if (is_remove && pair_hit) begin
                    n_state = S_REM1;
                end
            end
            S_REM1: n_state = (cnt_dec == '0) ? S_RESP : S_REM2;
            S_REM2: n_state = S_RESP;
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_free       = r_free;
        n_count      = r_count;
        n_pend       = r_pend;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_value      = r_value;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_nxt        = r_nxt;
        n_slot       = r_slot;
        n_steps      = r_steps;
        n_pend_val   = r_pend_val;
        n_rsp_status = r_rsp_status;
        n_rsp_val    = r_rsp_val;
        n_ovalid     = r_ovalid && !i_ready;
        n_ostatus    = r_ostatus;
        n_oval       = r_oval;
        n_olast      = r_olast;
        n_ototal     = r_ototal;
        o_ready      = 1'b0;
        link_clear   = 1'b0;
        link_we      = 1'b0;
        link_waddr   = r_free[AW-1:0];
        link_wdata   = NONE;
        link_raddr   = r_cur[AW-1:0];
        kv_we        = 1'b0;
        kv_waddr     = r_free[AW-1:0];
        kv_wdata     = {r_key, r_value};
        kv_raddr     = r_cur[AW-1:0];

        case (r_state)
            S_IDLE: begin
                o_ready    = 1'b1;
                link_raddr = (i_command == CMD_ADD) ? r_free[AW-1:0] : r_head[AW-1:0];
                kv_raddr   = r_head[AW-1:0];
                if (i_valid) begin
                    n_cmd        = i_command;
                    n_key        = i_key;
                    n_value      = i_value;
                    n_cur        = r_head;
                    n_prev       = NONE;
                    n_steps      = '0;
                    n_pend       = 1'b0;
                    n_rsp_val    = '0;
                    n_rsp_status = (i_command == CMD_ADD) ? STAT_FULL : STAT_DONE;
                end
            end
            S_ADD1: begin
                kv_we   = 1'b1;
                link_we = 1'b1;
                n_slot  = r_free;
                n_free  = link_q;
            end
            S_ADD2: begin
                if (r_tail < NONE) begin
                    link_we    = 1'b1;
                    link_waddr = r_tail[AW-1:0];
                    link_wdata = r_slot;
                end else begin
                    n_head = r_slot;
                end
                n_tail       = r_slot;
                n_count      = r_count + LW'(1);
                n_rsp_status = STAT_DONE;
            end
            S_WALK: begin
                if (walk_adv) begin
                    link_raddr = link_q[AW-1:0];
                    kv_raddr   = link_q[AW-1:0];
                end
                if (!cur_ok) begin
                    if (!is_remove && r_pend) begin
                        n_rsp_status = STAT_HIT;
                        n_rsp_val    = r_pend_val;
                    end else begin
                        n_rsp_status = STAT_NOT_FOUND;
                    end
                end else if (is_remove && pair_hit) begin
                    n_slot = r_cur;
                    n_nxt  = link_q;
                end else if (walk_adv) begin
                    n_prev  = r_cur;
                    n_cur   = link_q;
                    n_steps = r_steps + LW'(1);
                    if (!is_remove && key_hit) begin
                        n_pend     = 1'b1;
                        n_pend_val = kv_q[FIELD_W-1:0];
                        if (r_pend) begin
                            n_ovalid  = 1'b1;
                            n_ostatus = STAT_HIT;
                            n_oval    = r_pend_val;
                            n_olast   = 1'b0;
                            n_ototal  = r_count;
                        end
                    end
                end
            end
            S_REM1: begin
                n_rsp_status = STAT_DONE;
                if (cnt_dec == '0) begin
                    link_clear = 1'b1;
                    n_head     = NONE;
                    n_tail     = NONE;
                    n_free     = '0;
                    n_count    = '0;
                end else begin
                    if (r_prev < NONE) begin
                        link_we    = 1'b1;
                        link_waddr = r_prev[AW-1:0];
                        link_wdata = r_nxt;
                    end else begin
                        n_head = r_nxt;
                    end
                    if (r_nxt >= NONE) begin
                        n_tail = r_prev;
                    end
                    n_count = cnt_dec;
                end
            end
            S_REM2: begin
                link_we    = 1'b1;
                link_waddr = r_slot[AW-1:0];
                link_wdata = r_free;
                n_free     = r_slot;
            end
            S_RESP: begin
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_rsp_status;
                    n_oval    = r_rsp_val;
                    n_olast   = 1'b1;
                    n_ototal  = r_count;
                end
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= NONE;
            r_tail   <= NONE;
            r_free   <= '0;
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_free   <= n_free;
            r_count  <= n_count;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_value      <= n_value;
        r_cur        <= n_cur;
        r_prev       <= n_prev;
        r_nxt        <= n_nxt;
        r_slot       <= n_slot;
        r_steps      <= n_steps;
        r_pend_val   <= n_pend_val;
        r_rsp_status <= n_rsp_status;
        r_rsp_val    <= n_rsp_val;
        r_ostatus    <= n_ostatus;
        r_oval       <= n_oval;
        r_olast      <= n_olast;
        r_ototal     <= n_ototal;
    end

    assign o_valid       = r_ovalid;
    assign o_status      = r_ostatus;
    assign o_found_value = r_oval;
    assign o_last        = r_olast;
    assign o_pair_total  = TOTAL_W'(r_ototal);

endmodule

>>> tb/tb_array_linked_list_multimap_core.sv
`timescale 1ns / 100ps

module tb_array_linked_list_multimap_core import alm_pkg::*;;

    localparam int unsigned SLOTS            = 64;
    localparam logic [6:0]  NO_LINK          = 7'd64;
    localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;
    localparam logic signed [FIELD_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [FIELD_W-1:0] KEY_MAX = 32'sh7fff_ffff;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int STALL_LIMIT      = 5000;
    localparam int TAIL_CYCLES      = 100;

    typedef enum logic [1:0] {
        ITEM_CMD,
        ITEM_DRAIN,
        ITEM_LONG_HOLD,
        ITEM_QUIET
    } item_kind_t;

    typedef struct {
        item_kind_t                 kind;
        logic [CMD_W-1:0]           cmd;
        logic signed [FIELD_W-1:0]  key;
        logic signed [FIELD_W-1:0]  value;
    } stim_item_t;

    typedef struct {
        logic [STATUS_W-1:0]        status;
        logic signed [FIELD_W-1:0]  value;
        logic                       last;
        logic [TOTAL_W-1:0]         total;
    } map_result_t;

    typedef struct {
        logic signed [FIELD_W-1:0]  k;
        logic signed [FIELD_W-1:0]  v;
    } pair_t;

    logic                       i_clk;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_ready;
    logic [CMD_W-1:0]           i_command = CMD_ADD;
    logic signed [FIELD_W-1:0]  i_key = '0;
    logic signed [FIELD_W-1:0]  i_value = '0;
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    logic [STATUS_W-1:0]        o_status;
    logic signed [FIELD_W-1:0]  o_found_value;
    logic                       o_last;
    logic [TOTAL_W-1:0]         o_pair_total;

    array_linked_list_multimap_core #(
        .CAPACITY(SLOTS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_command(i_command),
        .i_key(i_key),
        .i_value(i_value),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_status(o_status),
        .o_found_value(o_found_value),
        .o_last(o_last),
        .o_pair_total(o_pair_total)
    );

    // map model
    logic signed [FIELD_W-1:0] mm_key [SLOTS];
    logic signed [FIELD_W-1:0] mm_val [SLOTS];
    logic [6:0] mm_next [SLOTS];
    logic [6:0] mm_prev [SLOTS];
    logic [6:0] mm_head, mm_tail, mm_free, mm_count;

    map_result_t expected_results[$];
    stim_item_t  pending_items[$];
    pair_t       stored_pairs[$];

    logic stim_done      = 1'b0;
    logic long_hold_req  = 1'b0;
    logic long_hold_done = 1'b0;
    logic quiet_mode     = 1'b0;
    int   items_sent     = 0;
    int   tx_gap         = 0;
    int   rx_wait        = 0;
    int   rx_cycle       = 0;
    int   idle_cycles    = 0;
    int   mismatches     = 0;

    function automatic void rebuild_free_chain();
        for (int i = 0; i < SLOTS; i++) begin
            mm_next[i] = (i + 1 < SLOTS) ? 7'(i + 1) : NO_LINK;
            mm_prev[i] = (i == 0) ? NO_LINK : 7'(i - 1);
        end
        mm_head = NO_LINK;
        mm_tail = NO_LINK;
        mm_free = '0;
    endfunction

    function automatic logic [STATUS_W-1:0] link_pair(input logic signed [FIELD_W-1:0] k,
                                                      input logic signed [FIELD_W-1:0] v);
        logic [6:0] s;
        s = mm_free;
        if (s >= SLOTS || mm_count >= SLOTS) return STAT_FULL;
        mm_free = mm_next[s];
        if (mm_free < SLOTS) mm_prev[mm_free] = NO_LINK;
        mm_key[s]  = k;
        mm_val[s]  = v;
        mm_next[s] = NO_LINK;
        mm_prev[s] = mm_tail;
        if (mm_tail < SLOTS) mm_next[mm_tail] = s;
        else mm_head = s;
        mm_tail  = s;
        mm_count = mm_count + 7'd1;
        return STAT_DONE;
    endfunction

    function automatic logic [STATUS_W-1:0] unlink_pair(input logic signed [FIELD_W-1:0] k,
                                                        input logic signed [FIELD_W-1:0] v);
        logic [6:0] idx, p, n;
        idx = mm_head;
        for (int steps = 0; steps < SLOTS && idx < SLOTS; steps++) begin
            if (mm_key[idx] == k && mm_val[idx] == v) begin
                p = mm_prev[idx];
                n = mm_next[idx];
                if (p < SLOTS) mm_next[p] = n;
                else mm_head = n;
                if (n < SLOTS) mm_prev[n] = p;
                else mm_tail = p;
                if (mm_count > 0) mm_count = mm_count - 7'd1;
                if (mm_count == 0) begin
                    rebuild_free_chain();
                end else begin
                    mm_next[idx] = mm_free;
                    mm_prev[idx] = NO_LINK;
                    if (mm_free < SLOTS) mm_prev[mm_free] = idx;
                    mm_free = idx;
                end
                return STAT_DONE;
            end
            idx = mm_next[idx];
        end
        return STAT_NOT_FOUND;
    endfunction

    function automatic void predict_command(input logic [CMD_W-1:0] cmd,
                                            input logic signed [FIELD_W-1:0] k,
                                            input logic signed [FIELD_W-1:0] v);
        map_result_t r, held;
        logic        have_hit;
        logic [6:0]  idx;
        r.value  = '0;
        r.last   = 1'b1;
        have_hit = 1'b0;
        held     = r;
        case (cmd)
            CMD_ADD: begin
                r.status = link_pair(k, v);
            end
            CMD_REMOVE: begin
                r.status = unlink_pair(k, v);
            end
            CMD_SEARCH: begin
                r.status = STAT_NOT_FOUND;
                idx = mm_head;
                for (int steps = 0; steps < SLOTS && idx < SLOTS; steps++) begin
                    if (mm_key[idx] == k) begin
                        if (have_hit) expected_results.push_back(held);
                        held.status = STAT_HIT;
                        held.value  = mm_val[idx];
                        held.last   = 1'b0;
                        held.total  = mm_count;
                        have_hit    = 1'b1;
                    end
                    idx = mm_next[idx];
                end
            end
            default: begin
                r.status = STAT_DONE;
            end
        endcase
        if (have_hit) begin
            held.last = 1'b1;
            expected_results.push_back(held);
        end else begin
            r.total = mm_count;
            expected_results.push_back(r);
        end
    endfunction

    // stimulus generation
    function automatic void queue_command(input logic [CMD_W-1:0] cmd,
                                          input logic signed [FIELD_W-1:0] k,
                                          input logic signed [FIELD_W-1:0] v);
        stim_item_t it;
        it.kind  = ITEM_CMD;
        it.cmd   = cmd;
        it.key   = k;
        it.value = v;
        pending_items.push_back(it);
    endfunction

    function automatic void queue_marker(input item_kind_t kind);
        stim_item_t it;
        it.kind  = kind;
        it.cmd   = CMD_ADD;
        it.key   = '0;
        it.value = '0;
        pending_items.push_back(it);
    endfunction

    function automatic void queue_add(input logic signed [FIELD_W-1:0] k,
                                      input logic signed [FIELD_W-1:0] v);
        pair_t pr;
        pr.k = k;
        pr.v = v;
        queue_command(CMD_ADD, k, v);
        if (stored_pairs.size() < SLOTS) stored_pairs.push_back(pr);
    endfunction

    function automatic void queue_remove(input logic signed [FIELD_W-1:0] k,
                                         input logic signed [FIELD_W-1:0] v);
        int hit;
        hit = -1;
        queue_command(CMD_REMOVE, k, v);
        foreach (stored_pairs[j]) begin
            if (hit < 0 && stored_pairs[j].k == k && stored_pairs[j].v == v) hit = j;
        end
        if (hit >= 0) stored_pairs.delete(hit);
    endfunction

    function automatic logic signed [FIELD_W-1:0] pick_key();
        case ($urandom_range(0, 9))
            0, 1, 2: pick_key = $urandom;
            3:       pick_key = KEY_MIN;
            4:       pick_key = KEY_MAX;
            5:       pick_key = -32'sd1;
            6:       pick_key = 32'sd0;
            7:       pick_key = 32'sd7;
            default: pick_key = 32'sd1;
        endcase
    endfunction

    function automatic logic signed [FIELD_W-1:0] pick_value();
        if ($urandom_range(0, 9) < 6) pick_value = $urandom_range(0, 3);
        else pick_value = $urandom;
    endfunction

    function automatic void random_step(input int add_pct, input int rem_pct, input int srch_pct);
        int    r;
        pair_t pr;
        r = $urandom_range(0, 99);
        if (r < add_pct) begin
            queue_add(pick_key(), pick_value());
        end else if (r < add_pct + rem_pct) begin
            if (stored_pairs.size() > 0 && $urandom_range(0, 9) < 9) begin
                pr = stored_pairs[$urandom_range(0, stored_pairs.size() - 1)];
                if ($urandom_range(0, 9) == 0) queue_remove(pr.k, pr.v ^ 32'sd1);
                else queue_remove(pr.k, pr.v);
            end else begin
                queue_remove(pick_key(), pick_value());
            end
        end else if (r < add_pct + rem_pct + srch_pct) begin
            if (stored_pairs.size() > 0 && $urandom_range(0, 1) == 1)
                queue_command(CMD_SEARCH,
                              stored_pairs[$urandom_range(0, stored_pairs.size() - 1)].k,
                              pick_value());
            else
                queue_command(CMD_SEARCH, pick_key(), pick_value());
        end else begin
            queue_command(CMD_UNUSED, pick_key(), pick_value());
        end
    endfunction

    task automatic flag_mismatch(input string what, input logic [FIELD_W-1:0] got,
                                 input logic [FIELD_W-1:0] want);
        if (mismatches < 50)
            $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            mm_key[i] = '0;
            mm_val[i] = '0;
        end
        rebuild_free_chain();
        mm_count = '0;

        queue_command(CMD_SEARCH, 32'sd5, 32'sd0);
        queue_remove(32'sd5, 32'sd5);
        queue_command(CMD_UNUSED, -32'sd1, -32'sd1);
        queue_add(KEY_MIN, KEY_MAX);
        queue_add(KEY_MAX, KEY_MIN);
        queue_add(32'sd0, 32'sd0);
        queue_add(-32'sd1, -32'sd1);
        queue_add(KEY_MIN, 32'sd1);
        queue_command(CMD_SEARCH, KEY_MIN, 32'sd0);
        queue_remove(KEY_MIN, 32'sd2);
        queue_remove(KEY_MIN, KEY_MAX);
        queue_remove(KEY_MIN, 32'sd1);
        queue_remove(32'sd0, 32'sd0);
        queue_command(CMD_SEARCH, KEY_MAX, -32'sd1);
        queue_command(CMD_SEARCH, 32'sd0, 32'sd0);
        queue_add(KEY_MIN, 32'sd1);
        queue_command(CMD_SEARCH, -32'sd1, 32'sd0);
        queue_remove(KEY_MAX, KEY_MIN);
        queue_remove(-32'sd1, -32'sd1);
        queue_remove(KEY_MIN, 32'sd1);
        queue_command(CMD_SEARCH, KEY_MIN, 32'sd0);
        queue_add(32'sd3, 32'sd3);
        queue_add(32'sd3, 32'sd4);
        queue_command(CMD_SEARCH, 32'sd3, 32'sd0);
        queue_command(CMD_UNUSED, $urandom, $urandom);

        queue_marker(ITEM_DRAIN);
        repeat (40) random_step(45, 30, 20);
        queue_marker(ITEM_DRAIN);
        queue_marker(ITEM_LONG_HOLD);
        repeat (70) random_step(85, 0, 15);
        while (stored_pairs.size() > 0) random_step(0, 90, 10);
        queue_marker(ITEM_QUIET);
        repeat (25) random_step(40, 30, 25);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!stim_done || expected_results.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid   <= 1'b0;
            stim_done <= 1'b0;
            tx_gap    = 0;
        end else begin
            if (i_valid && o_ready) begin
                predict_command(i_command, i_key, i_value);
                items_sent++;
                if (!quiet_mode && (items_sent / 24) % 2 == 0 && $urandom_range(0, 2) == 0)
                    tx_gap = $urandom_range(1, 4);
            end
            if (!i_valid || o_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_valid <= 1'b0;
                end else if (pending_items.size() == 0) begin
                    i_valid   <= 1'b0;
                    stim_done <= 1'b1;
                end else begin
                    case (pending_items[0].kind)
                        ITEM_CMD: begin
                            i_command <= pending_items[0].cmd;
                            i_key     <= pending_items[0].key;
                            i_value   <= pending_items[0].value;
                            i_valid   <= 1'b1;
                            void'(pending_items.pop_front());
                        end
                        ITEM_DRAIN: begin
                            i_valid <= 1'b0;
                            if (expected_results.size() == 0) void'(pending_items.pop_front());
                        end
                        ITEM_LONG_HOLD: begin
                            i_valid       <= 1'b0;
                            long_hold_req <= 1'b1;
                            void'(pending_items.pop_front());
                        end
                        default: begin
                            i_valid    <= 1'b0;
                            quiet_mode <= 1'b1;
                            void'(pending_items.pop_front());
                        end
                    endcase
                end
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            rx_cycle++;
            if (long_hold_req && !long_hold_done) begin
                long_hold_done <= 1'b1;
                rx_wait = LONG_HOLD_CYCLES;
            end
            if (rx_wait > 0) begin
                rx_wait--;
                i_ready <= 1'b0;
            end else if (!quiet_mode && (rx_cycle / 150) % 2 == 0 && $urandom_range(0, 4) == 0) begin
                rx_wait = $urandom_range(0, 3);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        map_result_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                flag_mismatch("result with no command waiting", 32'(o_status), '0);
            end else begin
                want = expected_results.pop_front();
                if (o_status !== want.status)
                    flag_mismatch("status", 32'(o_status), 32'(want.status));
                if (o_found_value !== want.value)
                    flag_mismatch("found_value", o_found_value, want.value);
                if (o_last !== want.last)
                    flag_mismatch("last", 32'(o_last), 32'(want.last));
                if (o_pair_total !== want.total)
                    flag_mismatch("pair_total", 32'(o_pair_total), 32'(want.total));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule
